@@ src/twbp_pkg.sv @@
// Shared constants, types and helpers for the trie word-break prefix block.
`default_nettype none
package twbp_pkg;
  localparam int unsigned ALPHA      = 26;
  localparam int unsigned TRIE_NODES = 256;
  localparam int unsigned NODE_W     = $clog2(TRIE_NODES);
  localparam int unsigned MAX_WORD   = 10;
  localparam int unsigned LEN_W      = $clog2(MAX_WORD + 2);
  localparam int unsigned LET_W      = 5;
  localparam int unsigned MAX_TEXT   = 1048576;
  localparam int unsigned POS_W      = 21;
  localparam int unsigned SLOTS      = TRIE_NODES * ALPHA;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned WIN_W      = MAX_WORD + 1;

  // Command codes passed from front to back
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERROR  = 2'd1,
    OP_TEXT   = 2'd2
  } op_e;

  // One queued command; a text letter travels in word[0]
  typedef struct packed {
    op_e                            op;
    logic [MAX_WORD-1:0][LET_W-1:0] word;
    logic [LEN_W-1:0]               len;
    logic                           last;
  } cmd_t;

  // Child table address: node * 26 + letter, built from shifts
  function automatic logic [SLOT_W-1:0] slot_addr(input logic [NODE_W-1:0] node,
                                                  input logic [LET_W-1:0] x);
    logic [SLOT_W-1:0] n;
    n = SLOT_W'(node);
    return (n << 4) + (n << 3) + (n << 1) + SLOT_W'(x);
  endfunction
endpackage
`default_nettype wire

@@ src/trie_word_break_prefix_top.sv @@
// Top level: word-break prefix finder over a reversed-word trie.
// Input channel (in_valid_i / in_stall_o): one letter word per handshake,
//   kind_i = 0 for a dictionary letter, 1 for a text letter, last_i ends
//   the dictionary word or the text.
// Output channel (out_valid_o / out_stall_i): one word per text, given on
//   its last letter: prefix_len_o is the longest prefix split fully into
//   dictionary words, dict_error_o the sticky dictionary error flag.
// A two-entry command queue sits between the input side and the trie
//   engine; the input stalls only when that queue is full.
// Steps: a dictionary word is inserted with one child table read and
//   check per trie level. A text letter walks up to MAX_WORD trie levels,
//   with a read and a check per level, then a finish step;
//   a text end adds a step through the result register.
// Reset: the trie is cleared by a pass over all 26*TRIE_NODES = 6656
//   child table entries, one a cycle; input words queue meanwhile until full.
// A result held by out_stall_i stalls the engine once the next text end
//   reaches the result step; words before that text end keep flowing.
`default_nettype none
module trie_word_break_prefix_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        kind_i,
  input  wire logic [twbp_pkg::LET_W-1:0]  letter_i,
  input  wire logic                        last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [twbp_pkg::POS_W-1:0]       prefix_len_o,
  output logic                             dict_error_o
);
  logic           accept, push, full, pop, empty;
  twbp_pkg::cmd_t push_cmd, pop_cmd;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  twbp_front u_front (
    .clk_i, .rst_ni,
    .accept_i (accept),
    .kind_i, .letter_i, .last_i,
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  twbp_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_cmd_o  (pop_cmd)
  );

  twbp_back u_back (
    .clk_i, .rst_ni,
    .empty_i      (empty),
    .cmd_i        (pop_cmd),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .prefix_len_o,
    .dict_error_o
  );
endmodule
`default_nettype wire

@@ src/twbp_fifo.sv @@
// Two-entry command queue between the front and back parts.
`default_nettype none
module twbp_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire twbp_pkg::cmd_t push_cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output twbp_pkg::cmd_t      pop_cmd_o
);
  twbp_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end
endmodule
`default_nettype wire

@@ src/twbp_front.sv @@
// Front part: takes input words, buffers dictionary words, issues commands.
`default_nettype none
module twbp_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic                        kind_i,
  input  wire logic [twbp_pkg::LET_W-1:0]  letter_i,
  input  wire logic                        last_i,
  output logic                             push_o,
  output twbp_pkg::cmd_t                   cmd_o
);
  logic [twbp_pkg::MAX_WORD-1:0][twbp_pkg::LET_W-1:0] word_q, word_d;
  logic [twbp_pkg::LEN_W-1:0] wlen_q, wlen_d;
  logic                       bad_q, bad_d;
  logic                       bad_now;
  logic [twbp_pkg::LEN_W-1:0] wlen_now;

  // Word buffering and command build
  always_comb begin
    word_d   = word_q;
    wlen_d   = wlen_q;
    bad_d    = bad_q;
    bad_now  = bad_q || (letter_i >= twbp_pkg::LET_W'(twbp_pkg::ALPHA));
    wlen_now = wlen_q;
    if (wlen_q < twbp_pkg::LEN_W'(twbp_pkg::MAX_WORD)) begin
      word_d[wlen_q] = letter_i;
    end
    if (wlen_q <= twbp_pkg::LEN_W'(twbp_pkg::MAX_WORD)) begin
      wlen_now = wlen_q + twbp_pkg::LEN_W'(1);
    end
    push_o      = 1'b0;
    cmd_o.op    = twbp_pkg::OP_TEXT;
    cmd_o.word  = word_d;
    cmd_o.len   = wlen_now;
    cmd_o.last  = last_i;
    if (accept_i) begin
      if (kind_i) begin
        push_o     = 1'b1;
        cmd_o.word = '0;
        cmd_o.word[0] = letter_i;
      end else begin
        wlen_d = wlen_now;
        bad_d  = bad_now;
        if (last_i) begin
          wlen_d = '0;
          bad_d  = 1'b0;
          if (wlen_now > twbp_pkg::LEN_W'(twbp_pkg::MAX_WORD)) begin
            push_o   = 1'b1;
            cmd_o.op = twbp_pkg::OP_ERROR;
          end else if (!bad_now) begin
            push_o   = 1'b1;
            cmd_o.op = twbp_pkg::OP_INSERT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !kind_i) begin
      word_q <= word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= '0;
      bad_q  <= 1'b0;
    end else begin
      wlen_q <= wlen_d;
      bad_q  <= bad_d;
    end
  end
endmodule
`default_nettype wire

@@ src/twbp_back.sv @@
// Back part: trie memory, word insertion, text walk and result register.
`default_nettype none
module twbp_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        empty_i,
  input  wire twbp_pkg::cmd_t              cmd_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [twbp_pkg::POS_W-1:0]       prefix_len_o,
  output logic                             dict_error_o
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_IRD  = 3'd2;
  localparam logic [2:0] S_ICHK = 3'd3;
  localparam logic [2:0] S_TRD  = 3'd4;
  localparam logic [2:0] S_TCHK = 3'd5;
  localparam logic [2:0] S_TFIN = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam int unsigned NW = twbp_pkg::NODE_W;
  localparam int unsigned PW = twbp_pkg::POS_W;
  localparam int unsigned LW = twbp_pkg::LEN_W;
  localparam int unsigned AW = twbp_pkg::SLOT_W;

  logic [2:0]    st_q, st_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [twbp_pkg::MAX_WORD-1:0][twbp_pkg::LET_W-1:0] word_q, word_d;
  logic [twbp_pkg::MAX_WORD-1:0][twbp_pkg::LET_W-1:0] recent_q, recent_d;
  logic          last_q, last_d;
  logic [LW-1:0] k_q, k_d, len_q, len_d;
  logic [NW-1:0] node_q, node_d, nodes_q, nodes_d, nxt;
  logic [AW-1:0] addr_q, addr_d;
  logic          err_q, err_d, reach_q, reach_d;
  logic [twbp_pkg::WIN_W-1:0] win_q, win_d;
  logic [PW-1:0] tp_q, tp_d, best_q, best_d, pos_q, pos_d, pos_new;
  logic          out_valid_q, out_valid_d, out_err_q, out_err_d;
  logic [PW-1:0] out_prefix_q, out_prefix_d;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [NW:0]   wdata, rdata_q;
  logic [NW-1:0] rd_child;
  logic          rd_end;
  logic [twbp_pkg::LET_W-1:0] walk_x;

  // Each entry: {child is a word end, child node}; a node has one parent slot
  logic [NW:0] child_mem [twbp_pkg::SLOTS];

  assign out_valid_o  = out_valid_q;
  assign prefix_len_o = out_prefix_q;
  assign dict_error_o = out_err_q;
  assign walk_x       = recent_q[len_q - LW'(1)];
  assign pos_new      = tp_q + PW'(1);
  assign rd_child     = rdata_q[NW-1:0];
  assign rd_end       = rdata_q[NW];

  // Child table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      child_mem[waddr] <= wdata;
    end
    rdata_q <= child_mem[raddr];
  end

  // Sequencer
  always_comb begin
    st_d = st_q;  clr_d = clr_q;  word_d = word_q;  recent_d = recent_q;
    last_d = last_q;  k_d = k_q;  len_d = len_q;  node_d = node_q;
    nodes_d = nodes_q;  addr_d = addr_q;  err_d = err_q;
    reach_d = reach_q;  win_d = win_q;  tp_d = tp_q;  best_d = best_q;
    pos_d = pos_q;  out_prefix_d = out_prefix_q;  out_err_d = out_err_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o = 1'b0;  we = 1'b0;  waddr = addr_q;  wdata = '0;  nxt = rd_child;
    raddr = twbp_pkg::slot_addr(node_q, walk_x);
    unique case (st_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(twbp_pkg::SLOTS - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            twbp_pkg::OP_INSERT: begin
              word_d = cmd_i.word;
              k_d    = cmd_i.len;
              node_d = '0;
              st_d   = S_IRD;
            end
            twbp_pkg::OP_ERROR: err_d = 1'b1;
            default: begin
              last_d = cmd_i.last;
              if (tp_q >= PW'(twbp_pkg::MAX_TEXT)) begin
                st_d = cmd_i.last ? S_OUT : S_IDLE;
              end else if (pos_new > best_q + PW'(twbp_pkg::MAX_WORD)) begin
                tp_d = pos_new;
                st_d = cmd_i.last ? S_OUT : S_IDLE;
              end else begin
                recent_d = {recent_q[twbp_pkg::MAX_WORD-2:0], cmd_i.word[0]};
                pos_d    = pos_new;
                len_d    = LW'(1);
                node_d   = '0;
                reach_d  = 1'b0;
                st_d     = S_TRD;
              end
            end
          endcase
        end
      end
      S_IRD: begin
        raddr  = twbp_pkg::slot_addr(node_q, word_q[k_q - LW'(1)]);
        addr_d = raddr;
        st_d   = S_ICHK;
      end
      S_ICHK: begin
        if (rd_child == '0) begin
          if (nodes_q == NW'(twbp_pkg::TRIE_NODES - 1)) begin
            err_d = 1'b1;
            st_d  = S_IDLE;
          end else begin
            nxt     = nodes_q + NW'(1);
            nodes_d = nxt;
            we      = 1'b1;
            wdata   = {k_q == LW'(1), nxt};
          end
        end else if (k_q == LW'(1)) begin
          // Existing node ends the word: set its mark in the parent slot
          we    = 1'b1;
          wdata = {1'b1, rd_child};
        end
        if (!(rd_child == '0 && nodes_q == NW'(twbp_pkg::TRIE_NODES - 1))) begin
          k_d    = k_q - LW'(1);
          node_d = nxt;
          if (k_q == LW'(1)) begin
            st_d = S_IDLE;
          end else begin
            st_d = S_IRD;
          end
        end
      end
      S_TRD: begin
        if (len_q > LW'(twbp_pkg::MAX_WORD) || PW'(len_q) > pos_q ||
            walk_x >= twbp_pkg::LET_W'(twbp_pkg::ALPHA)) begin
          st_d = S_TFIN;
        end else begin
          st_d = S_TCHK;
        end
      end
      S_TCHK: begin
        if (rd_child == '0) begin
          st_d = S_TFIN;
        end else begin
          node_d = rd_child;
          if (rd_end && win_q[len_q - LW'(1)]) reach_d = 1'b1;
          len_d = len_q + LW'(1);
          st_d  = S_TRD;
        end
      end
      S_TFIN: begin
        win_d = {win_q[twbp_pkg::WIN_W-2:0], reach_q};
        tp_d  = pos_q;
        if (reach_q) best_d = pos_q;
        st_d = last_q ? S_OUT : S_IDLE;
      end
      default: begin
        // Result hand-off, then text state clears
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_prefix_d = best_q;
          out_err_d    = err_q;
          tp_d         = '0;
          best_d       = '0;
          win_d        = twbp_pkg::WIN_W'(1);
          st_d         = S_IDLE;
        end
      end
    endcase
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    recent_q     <= recent_d;
    last_q       <= last_d;
    k_q          <= k_d;
    len_q        <= len_d;
    node_q       <= node_d;
    addr_q       <= addr_d;
    reach_q      <= reach_d;
    pos_q        <= pos_d;
    out_prefix_q <= out_prefix_d;
    out_err_q    <= out_err_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLR;
      clr_q       <= '0;
      nodes_q     <= '0;
      err_q       <= 1'b0;
      win_q       <= twbp_pkg::WIN_W'(1);
      tp_q        <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      nodes_q     <= nodes_d;
      err_q       <= err_d;
      win_q       <= win_d;
      tp_q        <= tp_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Checks
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q) else $error("error flag dropped");
  a_no_out_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_CLR) |-> !out_valid_q) else $error("result during clearing pass");
  a_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_ICHK && rd_child == '0 && nodes_q != NW'(twbp_pkg::TRIE_NODES - 1))
    |=> nodes_q == $past(nodes_q) + NW'(1)) else $error("node not allocated");
  a_best_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q <= tp_q) else $error("best prefix beyond text position");
endmodule
`default_nettype wire

@@ sim/trie_word_break_prefix_top_tb.sv @@
// Testbench for the trie word-break prefix block: scoreboard class plus drivers.
`default_nettype none
module trie_word_break_prefix_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KIND_DICT = 0;
  localparam int KIND_TEXT = 1;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [twbp_pkg::POS_W-1:0] prefix_len;
    logic                       dict_error;
  } prefix_res_t;

  // Golden model of the trie and the text walk, plus pending results
  class prefix_scoreboard;
    int unsigned child[twbp_pkg::TRIE_NODES][twbp_pkg::ALPHA];
    bit          word_end[twbp_pkg::TRIE_NODES];
    int unsigned nodes_used;
    logic [twbp_pkg::LET_W-1:0] word_buf[twbp_pkg::MAX_WORD];
    int unsigned word_len;
    bit          word_bad;
    logic [twbp_pkg::LET_W-1:0] recent[twbp_pkg::MAX_WORD];
    logic [twbp_pkg::WIN_W-1:0] reach_win;
    int unsigned text_pos;
    int unsigned best_prefix;
    bit          err_flag;
    prefix_res_t pending[$];
    int          mismatches;
    int          results_seen;

    function new();
      foreach (child[n, a]) child[n][a] = 0;
      foreach (word_end[n]) word_end[n] = 0;
      nodes_used = 0;
      word_len = 0;
      word_bad = 0;
      err_flag = 0;
      mismatches = 0;
      results_seen = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (recent[k]) recent[k] = '0;
      reach_win = 1;
      text_pos = 0;
      best_prefix = 0;
    endfunction

    function void insert_word();
      int unsigned node;
      int unsigned x;
      node = 0;
      for (int k = int'(word_len) - 1; k >= 0; k--) begin
        x = word_buf[k];
        if (child[node][x] == 0) begin
          if (nodes_used + 1 >= twbp_pkg::TRIE_NODES) begin
            err_flag = 1;
            return;
          end
          nodes_used++;
          child[node][x] = nodes_used;
        end
        node = child[node][x];
      end
      word_end[node] = 1;
    endfunction

    function void text_step(logic [twbp_pkg::LET_W-1:0] letter);
      int unsigned pos;
      int unsigned node;
      int unsigned x;
      int unsigned nxt;
      bit reach;
      if (text_pos >= twbp_pkg::MAX_TEXT) return;
      pos = text_pos + 1;
      if (pos > best_prefix + twbp_pkg::MAX_WORD) begin
        text_pos = pos;
        return;
      end
      for (int k = twbp_pkg::MAX_WORD - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = letter;
      node = 0;
      reach = 0;
      for (int unsigned len = 1; len <= twbp_pkg::MAX_WORD && len <= pos; len++) begin
        x = recent[len-1];
        if (x >= twbp_pkg::ALPHA) break;
        nxt = child[node][x];
        if (nxt == 0 || nxt >= twbp_pkg::TRIE_NODES) break;
        node = nxt;
        if (word_end[node] && reach_win[len-1]) reach = 1;
      end
      reach_win = {reach_win[twbp_pkg::WIN_W-2:0], reach};
      text_pos = pos;
      if (reach) best_prefix = pos;
    endfunction

    // Note an accepted input word
    function void note_input(bit kind, logic [twbp_pkg::LET_W-1:0] letter, bit last);
      prefix_res_t r;
      if (kind == KIND_DICT) begin
        if (letter >= twbp_pkg::ALPHA) word_bad = 1;
        if (word_len < twbp_pkg::MAX_WORD) word_buf[word_len] = letter;
        if (word_len <= twbp_pkg::MAX_WORD) word_len++;
        if (!last) return;
        if (word_len > twbp_pkg::MAX_WORD) err_flag = 1;
        else if (!word_bad) insert_word();
        word_len = 0;
        word_bad = 0;
        return;
      end
      text_step(letter);
      if (!last) return;
      r.prefix_len = twbp_pkg::POS_W'(best_prefix);
      r.dict_error = err_flag;
      pending.push_back(r);
      clear_text();
    endfunction

    // Compare one result word with the oldest expectation
    function void check_result(logic [twbp_pkg::POS_W-1:0] plen, logic derr);
      prefix_res_t e;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: prefix_len=%0d dict_error=%0b", plen, derr);
        return;
      end
      e = pending.pop_front();
      if (e.prefix_len !== plen || e.dict_error !== derr) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected prefix_len=%0d dict_error=%0b, got %0d %0b",
                   e.prefix_len, e.dict_error, plen, derr);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic kind_i = 0;
  logic [twbp_pkg::LET_W-1:0] letter_i = '0;
  logic last_i = 0;
  logic out_stall_i = 0;
  logic in_stall_o, out_valid_o, dict_error_o;
  logic [twbp_pkg::POS_W-1:0] prefix_len_o;

  prefix_scoreboard sb;
  longint cycles = 0;
  bit long_hold = 0;
  bit rx_random = 1;
  int dict_words = 0;
  int texts_sent = 0;

  trie_word_break_prefix_top dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Cycle watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result sampling at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(prefix_len_o, dict_error_o);
  end

  // Receiver stall: random waits per result, or a long hold-off
  initial begin
    int w;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1;
      end else if (rx_random && out_valid_o && !out_stall_i) begin
        // hold stall pattern per result: a random stall, drawn anew for each result
        w = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w > 0) begin
          out_stall_i <= 1;
          repeat (w) @(negedge clk_i);
        end
        out_stall_i <= 0;
      end else begin
        out_stall_i <= ($urandom_range(0, 5) == 0) && rx_random;
      end
    end
  end

  // Offer one word and wait for its acceptance
  task automatic send_letter(bit kind, logic [twbp_pkg::LET_W-1:0] letter, bit last,
                             int gap);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1;
    kind_i <= kind;
    letter_i <= letter;
    last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(kind, letter, last);
    @(negedge clk_i);
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
  endfunction

  task automatic send_word(logic [twbp_pkg::LET_W-1:0] w[$]);
    foreach (w[i]) send_letter(KIND_DICT, w[i], i == w.size() - 1, draw_gap());
    dict_words++;
  endtask

  task automatic send_text(logic [twbp_pkg::LET_W-1:0] t[$]);
    foreach (t[i]) send_letter(KIND_TEXT, t[i], i == t.size() - 1, draw_gap());
    texts_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  // Dictionary kept small so text walks find matches
  logic [twbp_pkg::LET_W-1:0] vocab[$][$];

  task automatic add_vocab_word();
    logic [twbp_pkg::LET_W-1:0] w[$];
    int n;
    n = $urandom_range(1, 4);
    repeat (n) w.push_back(twbp_pkg::LET_W'($urandom_range(0, 5)));
    vocab.push_back(w);
    send_word(w);
  endtask

  task automatic random_text();
    logic [twbp_pkg::LET_W-1:0] t[$];
    int parts;
    int r;
    parts = $urandom_range(1, 6);
    repeat (parts) begin
      r = $urandom_range(0, 9);
      if (r < 7 && vocab.size() > 0) begin
        t = {t, vocab[$urandom_range(0, vocab.size() - 1)]};
      end else if (r < 9) begin
        t.push_back(twbp_pkg::LET_W'($urandom_range(0, 25)));
      end else begin
        t.push_back(twbp_pkg::LET_W'($urandom_range(0, 31)));
      end
    end
    send_text(t);
  endtask

  initial begin
    logic [twbp_pkg::LET_W-1:0] w[$];
    int sent;
    sb = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: extremes, bad letters, a maximum-length word, far letters
    send_word('{5'd0});
    send_word('{5'd25, 5'd0});
    send_word('{5'd1, 5'd31});           // bad letter discarded
    send_text('{5'd0, 5'd0, 5'd25, 5'd0});
    send_text('{5'd31});                 // bad text letter
    send_word('{5'd2, 5'd2, 5'd2, 5'd2, 5'd2,
                5'd2, 5'd2, 5'd2, 5'd2, 5'd2}); // max length
    send_text('{5'd2, 5'd2, 5'd2, 5'd2, 5'd2,
                5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd0});
    // Far letters past best prefix are ignored
    send_text('{5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
                5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd0,
                5'd0});
    drain();

    // Long receiver hold-off: sender keeps offering so the queue fills
    long_hold = 1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        long_hold = 0;
      end
      begin
        repeat (6) send_text('{5'd0, 5'd0});
        in_valid_i <= 0;
        @(negedge clk_i);
      end
    join
    drain();

    // Random: mostly vocabulary-built texts, some noise
    sent = 0;
    while (sent < 800) begin
      if (vocab.size() < 12 || $urandom_range(0, 9) == 0) begin
        add_vocab_word();
        sent += 3;
      end else begin
        random_text();
        sent += 6;
      end
      if ($urandom_range(0, 40) == 0) drain();   // sender waits for all results
    end
    drain();

    // Over-long word and trie overflow set the sticky flag
    w = {};
    repeat (12) w.push_back(twbp_pkg::LET_W'($urandom_range(0, 25)));
    send_word(w);
    repeat (30) begin
      w = {};
      repeat (10) w.push_back(twbp_pkg::LET_W'($urandom_range(0, 25)));
      send_word(w);
    end
    repeat (10) random_text();
    drain();
    repeat (60) @(negedge clk_i);

    $display("covered %0d dictionary words and %0d texts, %0d results checked",
             dict_words, texts_sent, sb.results_seen);
    $display("reset clear pass, far letters, bad letters, long words and trie overflow");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
src/twbp_pkg.sv
src/twbp_fifo.sv
src/twbp_front.sv
src/twbp_back.sv
src/trie_word_break_prefix_top.sv
sim/trie_word_break_prefix_top_tb.sv
